FILE: sv/cams_pkg.sv
// Shared constants, types and functions of the constrained-angle Metropolis step block
package cams_pkg;

    localparam int NUM_BINS  = 128;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int FRAC_BITS = 16;
    localparam int ANG_W     = FRAC_BITS + 2;
    localparam int TRIG_W    = 34;
    localparam int COS_W     = TRIG_W + 1;
    localparam int XJ_W      = 36;
    localparam int SIN_W     = 31;
    localparam int ITER_W    = 5;
    localparam int CORDIC_STEPS = 30;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 19;

    localparam logic [ANG_W-1:0]         PI_FRAC     = 18'd205887;
    localparam logic signed [TRIG_W-1:0] HALF_PI_W   = 34'sd1686629713;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XJ_W-1:0]   ONE_W       = 36'sd1073741824;

    localparam logic [SUM_W-1:0] RST_COSINE_SUM   = 19'd26214;
    localparam logic [15:0]      RST_STEP_SCALE   = 16'd9830;
    localparam logic [15:0]      RST_SAMPLE_EVERY = 16'd2;
    localparam logic [31:0]      RST_WARMUP_STEPS = 32'd10000;

    typedef enum logic [1:0] {
        REG_COSINE_SUM   = 2'd0,
        REG_STEP_SCALE   = 2'd1,
        REG_SAMPLE_EVERY = 2'd2,
        REG_WARMUP_STEPS = 2'd3
    } reg_addr_t;

    typedef enum logic [1:0] {
        KIND_STEP    = 2'd0,
        KIND_READ    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_AC_GO, S_AC_WAIT, S_RD, S_RD_DONE,
        S_MUL1, S_MUL2, S_MUL3, S_ADD, S_MOVE, S_TT_GO, S_TT_WAIT, S_XJ,
        S_TN_GO, S_TN_WAIT, S_TO_GO, S_TO_WAIT, S_LHS, S_CMP,
        S_MOD, S_MOD_END, S_BIN, S_HREAD, S_HUPD, S_OUT
    } state_t;

    function automatic logic [TRIG_W-1:0] atan_w(input logic [ITER_W-1:0] i);
        logic [TRIG_W-1:0] v;
        case (i)
            5'd0:  v = 34'd843314856;
            5'd1:  v = 34'd497837829;
            5'd2:  v = 34'd263043836;
            5'd3:  v = 34'd133525158;
            5'd4:  v = 34'd67021686;
            5'd5:  v = 34'd33543515;
            5'd6:  v = 34'd16775850;
            5'd7:  v = 34'd8388437;
            5'd8:  v = 34'd4194282;
            5'd9:  v = 34'd2097149;
            5'd10: v = 34'd1048575;
            5'd11: v = 34'd524287;
            5'd12: v = 34'd262143;
            5'd13: v = 34'd131071;
            5'd14: v = 34'd65535;
            5'd15: v = 34'd32767;
            5'd16: v = 34'd16383;
            5'd17: v = 34'd8191;
            5'd18: v = 34'd4095;
            5'd19: v = 34'd2047;
            5'd20: v = 34'd1023;
            5'd21: v = 34'd511;
            5'd22: v = 34'd255;
            5'd23: v = 34'd127;
            5'd24: v = 34'd63;
            5'd25: v = 34'd31;
            5'd26: v = 34'd15;
            5'd27: v = 34'd7;
            5'd28: v = 34'd3;
            5'd29: v = 34'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

FILE: sv/constrained_angle_metropolis_step_top.sv
// Top level of the constrained-angle Metropolis step block
//
// Channel  Direction  Handshake                  Content
// s_*      in         s_tvalid / s_tready        tuser kind, tdata step / read / restart request
// m_*      out        m_tvalid / m_tready        tdata one result per request
// APB      in/out     psel, penable, pready=1    four configuration registers at 4*i
//
// A step with the partner cosine out of range uses the shared CORDIC only for the trial angle;
// any other step also calls it 17 or 18 times in the arccosine bisection and for both sines.
// Every step then runs the remainder and, when it samples, the binning and histogram update.
// A restart runs a histogram clearing pass over all 128 bins plus the bisection.
// After reset the same clearing pass and bisection run before s_tready rises.
// A finished result waits in the output register; the next request is taken meanwhile.
module constrained_angle_metropolis_step_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,  // pick, rand_step, rand_accept, bin_select
    input  logic [1:0]    s_tuser,  // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [143:0]  m_tdata,  // accepted, angle_first, angle_second, sampled, sample_bin,
                                    // bin_count, samples_total, accepts_total, zero pad
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import cams_pkg::*;

    // configuration
    logic [SUM_W-1:0] cosine_sum_reg;
    logic [15:0]      step_scale_reg, sample_every_reg;
    logic [31:0]      warmup_steps_reg;
    logic             cfg_we;
    reg_addr_t        cfg_addr;

    // control
    state_t state_reg, state_next;
    logic   ac_init_reg, restart_reg;

    // request
    kind_t                kind_reg;
    logic                 pick_reg;
    logic [15:0]          rstep_reg, racc_reg;
    logic [BIN_W-1:0]     bsel_reg;

    // state of the sampler
    logic [ANG_W-1:0] ang0_reg, ang1_reg;
    logic [CNT_W-1:0] step_idx_reg, samp_cnt_reg, acc_cnt_reg;

    // datapath
    logic [47:0]              mul_p_reg, mul_res;
    logic [16:0]              mul_a, mag_hi_reg, pabs;
    logic [30:0]              mul_b;
    logic [33:0]              prod_lo_reg;
    logic                     pneg;
    logic [ANG_W-1:0]         d_reg, t_reg, lo_reg, hi_reg, mid_reg, mid;
    logic signed [XJ_W-1:0]   ac_tgt_reg, xj;
    logic signed [COS_W-1:0]  xi_reg;
    logic [SIN_W-1:0]         sjn_reg, sjo_reg;
    logic [18:0]              rem_reg, rem_sh, rem_sub, divisor;
    logic                     rem_ge;
    logic [BIN_W-1:0]         loop_cnt_reg, bin_q_reg;
    logic                     c_le, ac_more;
    logic [ANG_W-1:0]         lo_n, hi_n, ang_ip, ang_jp;
    logic                     xj_ok, do_sample;
    logic [51:0]              dsum;
    logic signed [19:0]       tsum, tabs, tfold;
    logic [TRIG_W-1:0]        sabs;
    logic [15:0]              period;

    // result
    logic             acc_f_reg, smp_f_reg;
    logic [BIN_W-1:0] sbin_reg;
    logic [31:0]      count_reg;
    logic [140:0]     out_reg;
    logic             m_tvalid_reg;

    // unit connections
    logic                     cd_start, cd_done;
    logic [ANG_W-1:0]         cd_angle;
    logic signed [COS_W-1:0]  cd_cos;
    logic signed [TRIG_W-1:0] cd_sin;
    logic                     ram_we, out_load;
    logic [BIN_W-1:0]         ram_waddr, ram_raddr;
    logic [31:0]              ram_wdata, ram_rdata;

    cams_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cd_start),
        .angle   (cd_angle),
        .done    (cd_done),
        .cos_val (cd_cos),
        .sin_val (cd_sin)
    );

    cams_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port
    assign pready   = 1'b1;
    assign cfg_addr = reg_addr_t'(paddr[3:2]);
    assign cfg_we   = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_addr)
            REG_COSINE_SUM:   prdata = {{(32-SUM_W){cosine_sum_reg[SUM_W-1]}}, cosine_sum_reg};
            REG_STEP_SCALE:   prdata = {16'd0, step_scale_reg};
            REG_SAMPLE_EVERY: prdata = {16'd0, sample_every_reg};
            REG_WARMUP_STEPS: prdata = warmup_steps_reg;
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cosine_sum_reg   <= RST_COSINE_SUM;
            step_scale_reg   <= RST_STEP_SCALE;
            sample_every_reg <= RST_SAMPLE_EVERY;
            warmup_steps_reg <= RST_WARMUP_STEPS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_COSINE_SUM:   cosine_sum_reg   <= pwdata[SUM_W-1:0];
                REG_STEP_SCALE:   step_scale_reg   <= pwdata[15:0];
                REG_SAMPLE_EVERY: sample_every_reg <= pwdata[15:0];
                REG_WARMUP_STEPS: warmup_steps_reg <= pwdata;
                default:          cosine_sum_reg   <= cosine_sum_reg;
            endcase
        end
    end

    // shared datapath terms
    always_comb
    begin
        ang_ip = pick_reg ? ang1_reg : ang0_reg;
        ang_jp = pick_reg ? ang0_reg : ang1_reg;
        mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
        c_le   = XJ_W'(cd_cos) <= ac_tgt_reg;
        lo_n   = c_le ? lo_reg : mid_reg + 1'b1;
        hi_n   = c_le ? mid_reg : hi_reg;
        ac_more = lo_n < hi_n;

        pneg = !rstep_reg[15];
        pabs = rstep_reg[15] ? {1'b0, rstep_reg[14:0], 1'b0}
                             : 17'd65536 - {rstep_reg, 1'b0};

        case (state_reg)
            S_MUL1:  begin mul_a = pabs;                      mul_b = {15'd0, step_scale_reg}; end
            S_MUL2:  begin mul_a = {1'b0, mul_p_reg[15:0]};   mul_b = {13'd0, PI_FRAC}; end
            S_MUL3:  begin mul_a = mag_hi_reg;                mul_b = {13'd0, PI_FRAC}; end
            default: begin mul_a = {1'b0, racc_reg};          mul_b = sjn_reg; end
        endcase
        mul_res = 48'(mul_a) * 48'(mul_b);

        dsum = {1'b0, mul_p_reg[34:0], 16'd0} + 52'(prod_lo_reg) + 52'h0_0000_8000_0000;

        tsum  = pneg ? $signed({2'b00, ang_ip}) - $signed({2'b00, d_reg})
                     : $signed({2'b00, ang_ip}) + $signed({2'b00, d_reg});
        tabs  = (tsum < 0) ? -tsum : tsum;
        tfold = (tabs > $signed({2'b00, PI_FRAC})) ? $signed({1'b0, PI_FRAC, 1'b0}) - tabs : tabs;

        xj    = $signed({{3{cosine_sum_reg[SUM_W-1]}}, cosine_sum_reg, 14'd0}) - XJ_W'(xi_reg);
        xj_ok = (xj <= ONE_W) && (xj >= -ONE_W);

        sabs = cd_sin[TRIG_W-1] ? -cd_sin : cd_sin;

        period  = (sample_every_reg == '0) ? 16'd1 : sample_every_reg;
        divisor = (state_reg == S_BIN) ? {1'b0, PI_FRAC} : {3'd0, period};
        rem_sh  = (state_reg == S_BIN) ? {rem_reg[17:0], 1'b0}
                                       : {rem_reg[17:0], step_idx_reg[~loop_cnt_reg[4:0]]};
        rem_ge  = rem_sh >= divisor;
        rem_sub = rem_ge ? rem_sh - divisor : rem_sh;

        do_sample = (rem_reg == '0) && (step_idx_reg > warmup_steps_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (kind_t'(s_tuser))
                        KIND_STEP:    state_next = S_MUL1;
                        KIND_RESTART: state_next = S_CLEAR;
                        default:      state_next = S_RD;
                    endcase
                end
            end
            S_CLEAR:   if (&loop_cnt_reg) state_next = S_AC_GO;
            S_AC_GO:   state_next = S_AC_WAIT;
            S_AC_WAIT:
            begin
                if (cd_done)
                begin
                    if (ac_more)
                        state_next = S_AC_GO;
                    else if (!ac_init_reg)
                        state_next = S_TN_GO;
                    else if (restart_reg)
                        state_next = S_OUT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_RD:      state_next = S_RD_DONE;
            S_RD_DONE: state_next = S_OUT;
            S_MUL1:    state_next = S_MUL2;
            S_MUL2:    state_next = S_MUL3;
            S_MUL3:    state_next = S_ADD;
            S_ADD:     state_next = S_MOVE;
            S_MOVE:    state_next = S_TT_GO;
            S_TT_GO:   state_next = S_TT_WAIT;
            S_TT_WAIT: if (cd_done) state_next = S_XJ;
            S_XJ:      state_next = xj_ok ? S_AC_GO : S_MOD;
            S_TN_GO:   state_next = S_TN_WAIT;
            S_TN_WAIT: if (cd_done) state_next = S_TO_GO;
            S_TO_GO:   state_next = S_TO_WAIT;
            S_TO_WAIT: if (cd_done) state_next = S_LHS;
            S_LHS:     state_next = S_CMP;
            S_CMP:     state_next = S_MOD;
            S_MOD:     if (&loop_cnt_reg[4:0]) state_next = S_MOD_END;
            S_MOD_END:
            begin
                if (!do_sample)
                    state_next = S_OUT;
                else if (ang_ip >= PI_FRAC)
                    state_next = S_HREAD;
                else
                    state_next = S_BIN;
            end
            S_BIN:     if (loop_cnt_reg == BIN_W'(BIN_W - 1)) state_next = S_HREAD;
            S_HREAD:   state_next = S_HUPD;
            S_HUPD:    state_next = S_OUT;
            S_OUT:     if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        cd_start  = 1'b0;
        cd_angle  = t_reg;
        ram_we    = 1'b0;
        ram_waddr = loop_cnt_reg;
        ram_wdata = '0;
        ram_raddr = bin_q_reg;
        out_load  = 1'b0;
        case (state_reg)
            S_CLEAR: ram_we = 1'b1;
            S_AC_GO: begin cd_start = 1'b1; cd_angle = mid; end
            S_TT_GO: cd_start = 1'b1;
            S_TN_GO: begin cd_start = 1'b1; cd_angle = lo_reg; end
            S_TO_GO: begin cd_start = 1'b1; cd_angle = ang_jp; end
            S_RD:    ram_raddr = bsel_reg;
            S_HUPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = bin_q_reg;
                ram_wdata = sat_inc(ram_rdata);
            end
            S_OUT:   out_load = !m_tvalid_reg || m_tready;
            default: ram_we = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            ac_init_reg  <= 1'b1;
            restart_reg  <= 1'b0;
            loop_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
            step_idx_reg <= '0;
            samp_cnt_reg <= '0;
            acc_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    loop_cnt_reg <= '0;
                    ac_init_reg  <= 1'b1;
                    restart_reg  <= 1'b1;
                end
                S_CLEAR:
                begin
                    loop_cnt_reg <= loop_cnt_reg + 1'b1;
                    step_idx_reg <= '0;
                    samp_cnt_reg <= '0;
                    acc_cnt_reg  <= '0;
                end
                S_XJ:      ac_init_reg  <= 1'b0;
                S_MUL1:    loop_cnt_reg <= '0;
                S_MOD:     loop_cnt_reg <= loop_cnt_reg + 1'b1;
                S_MOD_END:
                begin
                    loop_cnt_reg <= '0;
                    step_idx_reg <= step_idx_reg + 1'b1;
                end
                S_BIN:     loop_cnt_reg <= loop_cnt_reg + 1'b1;
                S_CMP:     if (mul_p_reg < {1'b0, sjo_reg, 16'd0}) acc_cnt_reg <= sat_inc(acc_cnt_reg);
                S_HUPD:    samp_cnt_reg <= sat_inc(samp_cnt_reg);
                default:   loop_cnt_reg <= loop_cnt_reg;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg  <= kind_t'(s_tuser);
                pick_reg  <= s_tdata[0];
                rstep_reg <= s_tdata[16:1];
                racc_reg  <= s_tdata[32:17];
                bsel_reg  <= s_tdata[39:33];
                acc_f_reg <= 1'b0;
                smp_f_reg <= 1'b0;
                sbin_reg  <= '0;
                count_reg <= '0;
            end
            S_CLEAR:
            begin
                lo_reg     <= '0;
                hi_reg     <= PI_FRAC;
                ac_tgt_reg <= $signed({{4{cosine_sum_reg[SUM_W-1]}}, cosine_sum_reg, 13'd0});
            end
            S_AC_GO:   mid_reg <= mid;
            S_AC_WAIT:
            begin
                if (cd_done)
                begin
                    lo_reg <= lo_n;
                    hi_reg <= hi_n;
                    if (!ac_more && ac_init_reg)
                    begin
                        ang0_reg <= lo_n;
                        ang1_reg <= lo_n;
                    end
                end
            end
            S_RD_DONE: count_reg <= (kind_reg == KIND_READ) ? ram_rdata : '0;
            S_MUL1:
            begin
                mul_p_reg <= mul_res;
                rem_reg   <= '0;
            end
            S_MUL2:
            begin
                mag_hi_reg <= mul_p_reg[32:16];
                mul_p_reg  <= mul_res;
            end
            S_MUL3:
            begin
                prod_lo_reg <= mul_p_reg[33:0];
                mul_p_reg   <= mul_res;
            end
            S_ADD:     d_reg <= dsum[32+ANG_W-1:32];
            S_MOVE:    t_reg <= tfold[ANG_W-1:0];
            S_TT_WAIT: if (cd_done) xi_reg <= cd_cos;
            S_XJ:
            begin
                lo_reg     <= '0;
                hi_reg     <= PI_FRAC;
                ac_tgt_reg <= xj;
            end
            S_TN_WAIT: if (cd_done) sjn_reg <= sabs[SIN_W-1:0];
            S_TO_WAIT: if (cd_done) sjo_reg <= sabs[SIN_W-1:0];
            S_LHS:     mul_p_reg <= mul_res;
            S_CMP:
            begin
                if (mul_p_reg < {1'b0, sjo_reg, 16'd0})
                begin
                    acc_f_reg <= 1'b1;
                    if (pick_reg)
                    begin
                        ang1_reg <= t_reg;
                        ang0_reg <= lo_reg;
                    end
                    else
                    begin
                        ang0_reg <= t_reg;
                        ang1_reg <= lo_reg;
                    end
                end
            end
            S_MOD:     rem_reg <= rem_sub;
            S_MOD_END:
            begin
                rem_reg   <= {1'b0, ang_ip};
                bin_q_reg <= BIN_W'(NUM_BINS - 1);
            end
            S_BIN:
            begin
                rem_reg   <= rem_sub;
                bin_q_reg <= {bin_q_reg[BIN_W-2:0], rem_ge};
            end
            S_HUPD:
            begin
                smp_f_reg <= 1'b1;
                sbin_reg  <= bin_q_reg;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_reg <= {acc_cnt_reg, samp_cnt_reg, count_reg, sbin_reg, smp_f_reg,
                                ang1_reg, ang0_reg, acc_f_reg};
                end
            end
            default: d_reg <= d_reg;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg};

endmodule

FILE: sv/cams_ram.sv
// Generic single-write, single-read RAM with registered read data
module cams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/cams_cordic.sv
// Iterative rotation CORDIC: cosine and sine of an angle in [0,pi], one iteration a cycle
module cams_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [cams_pkg::ANG_W-1:0]        angle,
    output logic                              done,
    output logic signed [cams_pkg::COS_W-1:0] cos_val,
    output logic signed [cams_pkg::TRIG_W-1:0] sin_val
);
    import cams_pkg::*;

    logic signed [TRIG_W-1:0] x_reg, y_reg, z_reg;
    logic signed [TRIG_W-1:0] x_next, y_next, z_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [TRIG_W-1:0] xs, ys, at;

    always_comb
    begin
        xs = x_reg >>> iter_reg;
        ys = y_reg >>> iter_reg;
        at = $signed(atan_w(iter_reg));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({2'b00, angle, 14'd0}) - HALF_PI_W;
            iter_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign cos_val = -COS_W'(y_reg);
    assign sin_val = x_reg;

endmodule

FILE: sv/cams_checker.sv
// Port-level checker of the constrained-angle Metropolis step block, bound to the top level
module cams_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [143:0]  m_tdata
);

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in work");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[18:1] <= 18'd205887) && (m_tdata[36:19] <= 18'd205887)))
        else $error("angle above pi");

    a_bin_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[37]) |-> (m_tdata[44:38] == 7'd0))
        else $error("bin index without a sample");

endmodule

bind constrained_angle_metropolis_step_top cams_checker u_cams_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
